// ----- design/ocvm_pkg.sv -----
// ----------------------------------------------------------------------------
// ocvm_pkg
// Types and constants shared by the orbit camera view matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package ocvm_pkg;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MOVE    = 2'd2,
    OP_VIEW    = 2'd3
  } op_e;

  localparam logic [1:0] BTN_SCROLL_UP   = 2'd1;
  localparam logic [1:0] BTN_SCROLL_DOWN = 2'd2;

  localparam logic [2:0] REG_ANGLE_GAIN  = 3'd0;
  localparam logic [2:0] REG_ELEV_LIMIT  = 3'd1;
  localparam logic [2:0] REG_RADIUS_MIN  = 3'd2;
  localparam logic [2:0] REG_RADIUS_MAX  = 3'd3;
  localparam logic [2:0] REG_RADIUS_STEP = 3'd4;

  localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
  localparam logic [22:0] QUARTER = 23'd4194304;

  // Polynomial coefficients, highest degree first, signs included.
  localparam logic signed [31:0] SC11 = -32'sd3864;
  localparam logic signed [31:0] SC9  = 32'sd172272;
  localparam logic signed [31:0] SC7  = -32'sd5026994;
  localparam logic signed [31:0] SC5  = 32'sd85569310;
  localparam logic signed [31:0] SC3  = -32'sd693598668;
  localparam logic signed [31:0] SC1  = 32'sd1686629713;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVENT,
    ST_ZERO,
    ST_SQ,
    ST_HORNER,
    ST_FINAL,
    ST_STORE,
    ST_PROD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       do_event;
    logic       load_angle;  // latch remainder of angle sel_q, seed p with SC11
    logic [1:0] sel;         // 0 az sin, 1 az cos, 2 el sin, 3 el cos
    logic       do_sq;
    logic       do_horner;
    logic [2:0] coef_idx;
    logic       do_final;
    logic       do_store;
    logic       do_prod;
    logic [1:0] prod_idx;
    logic       zero_mat;
    logic       out_load;
    logic [1:0] out_col;
  } ctrl_t;

  typedef struct packed {
    logic radius_zero;
  } stat_t;

  // Signed product shifted right, truncated toward zero.
  function automatic logic signed [63:0] mul_sh30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic        neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    neg = a[31] ^ b[31];
    ma  = a[31] ? (32'd0 - a) : a;
    mb  = b[31] ? (32'd0 - b) : b;
    p   = ({32'd0, ma} * {32'd0, mb}) >> 30;
    mul_sh30 = neg ? -$signed(p) : $signed(p);
  endfunction

  function automatic logic signed [31:0] q30_to_q16(input logic signed [31:0] v);
    logic [31:0] m;
    m = v[31] ? (32'd0 - v) : v;
    m = m >> 14;
    q30_to_q16 = v[31] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] coef(input logic [2:0] i);
    logic signed [31:0] c;
    unique case (i)
      3'd0: c = SC9;
      3'd1: c = SC7;
      3'd2: c = SC5;
      3'd3: c = SC3;
      3'd4: c = SC1;
      default: c = SC11;
    endcase
    coef = c;
  endfunction

endpackage

`default_nettype wire

// ----- design/orbit_camera_view_matrix.sv -----
// ----------------------------------------------------------------------------
// orbit_camera_view_matrix
// Orbit camera with a look-at view matrix in Q16.16.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_ready_o    operation, button, pointer, ui_consumed
// out      output     out_valid_o / out_ready_i  column, last, row0..row3
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Press, release and move requests are applied from the idle state. A view
// request runs four sine/cosine evaluations on one shared
// 32x32 multiplier, four products, then four columns through the output
// register. Zero radius skips the trig. Reset restores all camera state.
// ----------------------------------------------------------------------------
`default_nettype none

module orbit_camera_view_matrix (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [1:0]         button_i,
  input  wire logic signed [15:0] pointer_x_i,
  input  wire logic signed [15:0] pointer_y_i,
  input  wire logic               ui_consumed_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              column_o,
  output logic                    last_o,
  output logic signed [31:0]      row0_o,
  output logic signed [31:0]      row1_o,
  output logic signed [31:0]      row2_o,
  output logic signed [31:0]      row3_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  import ocvm_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  ocvm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i,
    .out_valid_o, .out_ready_i, .ctrl_o(ctrl), .stat_i(stat)
  );

  ocvm_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .operation_i, .button_i, .pointer_x_i, .pointer_y_i, .ui_consumed_i,
    .column_o, .last_o, .row0_o, .row1_o, .row2_o, .row3_o
  );

endmodule

`default_nettype wire

// ----- design/ocvm_datapath.sv -----
// ----------------------------------------------------------------------------
// ocvm_datapath
// Camera state, registers, shared trig multiplier and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ocvm_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ocvm_pkg::ctrl_t     ctrl_i,
  output ocvm_pkg::stat_t          stat_o,
  input  wire logic                cfg_valid_i,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire logic [1:0]          operation_i,
  input  wire logic [1:0]          button_i,
  input  wire logic signed [15:0]  pointer_x_i,
  input  wire logic signed [15:0]  pointer_y_i,
  input  wire logic                ui_consumed_i,
  output logic [1:0]               column_o,
  output logic                     last_o,
  output logic signed [31:0]       row0_o,
  output logic signed [31:0]       row1_o,
  output logic signed [31:0]       row2_o,
  output logic signed [31:0]       row3_o
);
  import ocvm_pkg::*;

  logic [15:0] gain_q;
  logic [21:0] lim_q;
  logic [31:0] rmin_q, rmax_q, rstep_q;
  logic [23:0] az_q, el_q;
  logic [31:0] radius_q;
  logic        drag_q, seen_q;
  logic signed [15:0] lx_q, ly_q;

  logic signed [31:0] x_q, x2_q, p_q;
  logic signed [31:0] sa_q, ca_q, se_q, ce_q;
  logic signed [31:0] pr_q [4];
  logic signed [31:0] m_q [4][4];

  // event arithmetic
  logic [32:0] lo_sum, up_sum;
  logic [31:0] lo_sat;
  logic signed [33:0] cand;
  logic signed [17:0] dx, dy;
  logic signed [34:0] gdx, gdy;
  logic signed [35:0] e_new;
  logic signed [35:0] lim_s;
  logic [23:0] angle, ang_sel;
  logic [21:0] rem;
  logic [22:0] r_eff;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] hsum;
  logic signed [63:0] pfin;
  logic signed [31:0] trig;
  logic               neg_sel;
  logic signed [31:0] pa, pb;

  assign stat_o.radius_zero = (radius_q == 32'd0);

  assign lo_sum = {1'b0, rmin_q} + {1'b0, rstep_q};
  assign lo_sat = lo_sum[32] ? 32'hFFFF_FFFF : lo_sum[31:0];
  assign cand   = $signed({2'b00, radius_q}) - $signed({2'b00, rstep_q});
  assign up_sum = {1'b0, radius_q} + {1'b0, rstep_q};
  assign dx     = 18'(pointer_x_i) - 18'(lx_q);
  assign dy     = 18'(pointer_y_i) - 18'(ly_q);
  assign gdx    = dx * $signed({1'b0, gain_q});
  assign gdy    = dy * $signed({1'b0, gain_q});
  assign e_new  = 36'($signed(el_q)) + 36'(gdy);
  assign lim_s  = $signed({14'd0, lim_q});

  // Trig operand selection: even sel is sine, odd cosine of angle.
  assign angle   = ctrl_i.sel[1] ? el_q : az_q;
  assign ang_sel = angle;
  assign rem     = ang_sel[21:0];
  // cos of quadrant q uses the complementary remainder when q is even
  always_comb begin
    logic use_comp;
    use_comp = ctrl_i.sel[0] ^ ang_sel[22];
    r_eff = use_comp ? (QUARTER - {1'b0, rem}) : {1'b0, rem};
    // sign: sin negative in q2,q3; cos negative in q1,q2
    if (ctrl_i.sel[0]) neg_sel = ang_sel[23] ^ ang_sel[22];
    else               neg_sel = ang_sel[23];
  end

  always_comb begin
    mul_a = x_q;
    mul_b = x_q;
    if (ctrl_i.do_horner) begin
      mul_a = p_q;
      mul_b = x2_q;
    end else if (ctrl_i.do_final) begin
      mul_a = p_q;
      mul_b = x_q;
    end else if (ctrl_i.do_prod) begin
      mul_a = pa;
      mul_b = pb;
    end
  end
  assign mul_p = mul_sh30(mul_a, mul_b);
  assign hsum  = mul_p + 64'(coef(ctrl_i.coef_idx));
  always_comb begin
    pfin = mul_p;
    if (pfin < 0) pfin = 64'sd0;
    if (pfin > ONE_Q30) pfin = ONE_Q30;
    trig = neg_sel ? -32'(pfin) : 32'(pfin);
  end

  always_comb begin
    unique case (ctrl_i.prod_idx)
      2'd0: begin pa = sa_q; pb = se_q; end
      2'd1: begin pa = ce_q; pb = sa_q; end
      2'd2: begin pa = ca_q; pb = se_q; end
      default: begin pa = ce_q; pb = ca_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= 16'd5340;
      lim_q    <= 22'd3774873;
      rmin_q   <= 32'd6553600;
      rmax_q   <= 32'd26214400;
      rstep_q  <= 32'd586172;
      az_q     <= '0;
      el_q     <= '0;
      radius_q <= 32'd19660800;
      drag_q   <= 1'b0;
      seen_q   <= 1'b0;
      lx_q     <= '0;
      ly_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_ANGLE_GAIN:  gain_q  <= cfg_data_i[15:0];
          REG_ELEV_LIMIT:  lim_q   <= cfg_data_i[21:0];
          REG_RADIUS_MIN:  rmin_q  <= cfg_data_i;
          REG_RADIUS_MAX:  rmax_q  <= cfg_data_i;
          REG_RADIUS_STEP: rstep_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctrl_i.do_event) begin
        unique case (op_e'(operation_i))
          OP_PRESS: begin
            if (!ui_consumed_i) begin
              drag_q <= 1'b1;
              if (button_i == BTN_SCROLL_UP) begin
                radius_q <= (cand > $signed({2'b00, lo_sat})) ? cand[31:0] : lo_sat;
              end else if (button_i == BTN_SCROLL_DOWN) begin
                radius_q <= (up_sum < {1'b0, rmax_q}) ? up_sum[31:0] : rmax_q;
              end
            end
          end
          OP_RELEASE: drag_q <= 1'b0;
          OP_MOVE: begin
            if (drag_q && seen_q) begin
              az_q <= az_q - gdx[23:0];
              if (e_new > lim_s)       el_q <= lim_s[23:0];
              else if (e_new < -lim_s) el_q <= 24'(-lim_s);
              else                     el_q <= e_new[23:0];
            end
            lx_q   <= pointer_x_i;
            ly_q   <= pointer_y_i;
            seen_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_angle) begin
      x_q <= $signed({1'b0, r_eff, 8'd0});
      p_q <= SC11;
    end
    if (ctrl_i.do_sq)     x2_q <= 32'(mul_p);
    if (ctrl_i.do_horner) p_q  <= 32'(hsum);
    if (ctrl_i.do_final)  p_q  <= trig;
    if (ctrl_i.do_store) begin
      unique case (ctrl_i.sel)
        2'd0: sa_q <= p_q;
        2'd1: ca_q <= p_q;
        2'd2: se_q <= p_q;
        default: ce_q <= p_q;
      endcase
    end
    if (ctrl_i.do_prod) pr_q[ctrl_i.prod_idx] <= 32'(mul_p);
    if (ctrl_i.out_load) begin
      column_o <= ctrl_i.out_col;
      last_o   <= (ctrl_i.out_col == 2'd3);
      row0_o   <= m_q[ctrl_i.out_col][0];
      row1_o   <= m_q[ctrl_i.out_col][1];
      row2_o   <= m_q[ctrl_i.out_col][2];
      row3_o   <= m_q[ctrl_i.out_col][3];
    end
  end

  always_comb begin
    logic signed [32:0] negr;
    negr = -$signed({1'b0, radius_q});
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 4; j++)
        m_q[k][j] = '0;
    m_q[3][3] = 32'sd65536;
    if (!ctrl_i.zero_mat) begin
      m_q[0][0] = q30_to_q16(ca_q);
      m_q[0][1] = q30_to_q16(-pr_q[0]);
      m_q[0][2] = q30_to_q16(pr_q[1]);
      m_q[1][1] = q30_to_q16(ce_q);
      m_q[1][2] = q30_to_q16(se_q);
      m_q[2][0] = q30_to_q16(-sa_q);
      m_q[2][1] = q30_to_q16(-pr_q[2]);
      m_q[2][2] = q30_to_q16(pr_q[3]);
      m_q[3][2] = (negr < -33'sd2147483648) ? 32'h8000_0000 : negr[31:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/ocvm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ocvm_ctrl
// Sequencer for events, four sine/cosine evaluations, products and column output.
// ----------------------------------------------------------------------------
`default_nettype none

module ocvm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       operation_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ocvm_pkg::ctrl_t       ctrl_o,
  input  wire ocvm_pkg::stat_t  stat_i
);
  import ocvm_pkg::*;

  state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] sel_q, sel_d;
  logic [1:0] col_q, col_d;
  logic       zero_q, zero_d;
  logic       ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sel_q   <= '0;
      col_q   <= '0;
      zero_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      col_q   <= col_d;
      zero_q  <= zero_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    col_d   = col_q;
    zero_d  = zero_q;
    ov_d    = ov_q;
    in_ready_o = 1'b0;
    ctrl_o  = '0;
    ctrl_o.sel      = sel_q;
    ctrl_o.coef_idx = cnt_q;
    ctrl_o.prod_idx = cnt_q[1:0];
    ctrl_o.zero_mat = zero_q;
    ctrl_o.out_col  = col_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (operation_i == OP_VIEW) begin
            zero_d  = stat_i.radius_zero;
            sel_d   = 2'd0;
            col_d   = 2'd0;
            state_d = stat_i.radius_zero ? ST_OUT : ST_ZERO;
          end else begin
            ctrl_o.do_event = 1'b1;
          end
        end
      end
      ST_ZERO: begin
        ctrl_o.load_angle = 1'b1;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        ctrl_o.do_sq = 1'b1;
        cnt_d = 3'd0;
        state_d = ST_HORNER;
      end
      ST_HORNER: begin
        ctrl_o.do_horner = 1'b1;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd4) state_d = ST_FINAL;
      end
      ST_FINAL: begin
        ctrl_o.do_final = 1'b1;
        state_d = ST_STORE;
      end
      ST_STORE: begin
        ctrl_o.do_store = 1'b1;
        sel_d = sel_q + 2'd1;
        cnt_d = 3'd0;
        state_d = (sel_q == 2'd3) ? ST_PROD : ST_ZERO;
      end
      ST_PROD: begin
        ctrl_o.do_prod = 1'b1;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd3) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          ov_d  = 1'b1;
          col_d = col_q + 2'd1;
          if (col_q == 2'd3) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HORNER) |-> cnt_q <= 3'd4)
    else $error("horner count overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |-> (!ov_q || out_ready_i))
    else $error("result overwritten");

endmodule

`default_nettype wire

// ----- bench/ocvm_checker.sv -----
// ----------------------------------------------------------------------------
// ocvm_checker
// Watches the request, result and register channels of the orbit camera,
// keeps its own copy of the camera state, predicts the view matrix columns
// and compares every result field by field in order.
// ----------------------------------------------------------------------------
module ocvm_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         operation_i,
  input  logic [1:0]         button_i,
  input  logic signed [15:0] pointer_x_i,
  input  logic signed [15:0] pointer_y_i,
  input  logic               ui_consumed_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         column_i,
  input  logic               last_i,
  input  logic signed [31:0] row0_i,
  input  logic signed [31:0] row1_i,
  input  logic signed [31:0] row2_i,
  input  logic signed [31:0] row3_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ocvm_pkg::*;

  typedef struct {
    logic [1:0]  col;
    logic        lst;
    logic [31:0] r [4];
  } column_t;

  column_t     columns_q[$];
  logic [15:0] gain;
  logic [21:0] elim;
  logic [31:0] rmin, rmax, rstep;
  logic [23:0] az, el;
  logic [31:0] rad;
  logic        drag, seen;
  logic signed [15:0] lx, ly;

  function automatic longint trunc_mul(longint a, longint b, int sh);
    longint ma, mb, p;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p  = (ma * mb) >>> sh;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic longint quarter_sine(longint r);
    longint x, x2, p;
    x  = r <<< 8;
    x2 = trunc_mul(x, x, 30);
    p  = -3864;
    p  = 172272 + trunc_mul(p, x2, 30);
    p  = -5026994 + trunc_mul(p, x2, 30);
    p  = 85569310 + trunc_mul(p, x2, 30);
    p  = -693598668 + trunc_mul(p, x2, 30);
    p  = 1686629713 + trunc_mul(p, x2, 30);
    p  = trunc_mul(p, x, 30);
    if (p < 0) p = 0;
    if (p > 64'sd1073741824) p = 64'sd1073741824;
    return p;
  endfunction

  task automatic sine_cosine(input logic [23:0] ang, output longint s, output longint c);
    longint a, b, r;
    r = longint'(ang[21:0]);
    a = quarter_sine(r);
    b = quarter_sine(64'sd4194304 - r);
    case (ang[23:22])
      2'd0: begin s = a; c = b; end
      2'd1: begin s = b; c = -a; end
      2'd2: begin s = -a; c = -b; end
      default: begin s = -b; c = a; end
    endcase
  endtask

  function automatic logic [31:0] to_q16(longint v);
    return 32'(trunc_mul(v, 1, 14));
  endfunction

  task automatic predict_view();
    longint  sa, ca, se, ce, negr;
    column_t c;
    logic [31:0] m [4][4];
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 4; j++) m[k][j] = '0;
    m[3][3] = 32'd65536;
    if (rad != 0) begin
      sine_cosine(az, sa, ca);
      sine_cosine(el, se, ce);
      m[0][0] = to_q16(ca);
      m[0][1] = to_q16(-trunc_mul(sa, se, 30));
      m[0][2] = to_q16(trunc_mul(ce, sa, 30));
      m[1][1] = to_q16(ce);
      m[1][2] = to_q16(se);
      m[2][0] = to_q16(-sa);
      m[2][1] = to_q16(-trunc_mul(ca, se, 30));
      m[2][2] = to_q16(trunc_mul(ce, ca, 30));
      negr = -longint'(rad);
      if (negr < -64'sd2147483648) negr = -64'sd2147483648;
      m[3][2] = 32'(negr);
    end
    for (int k = 0; k < 4; k++) begin
      c.col = 2'(k);
      c.lst = (k == 3);
      for (int j = 0; j < 4; j++) c.r[j] = m[k][j];
      columns_q.push_back(c);
    end
  endtask

  task automatic apply_request();
    longint lo, cand, e, g;
    case (op_e'(operation_i))
      OP_PRESS: if (!ui_consumed_i) begin
        drag = 1'b1;
        if (button_i == BTN_SCROLL_UP) begin
          lo = longint'(rmin) + longint'(rstep);
          if (lo > 64'hFFFF_FFFF) lo = 64'hFFFF_FFFF;
          cand = longint'(rad) - longint'(rstep);
          rad = 32'(cand > lo ? cand : lo);
        end else if (button_i == BTN_SCROLL_DOWN) begin
          cand = longint'(rad) + longint'(rstep);
          rad = 32'(cand < longint'(rmax) ? cand : longint'(rmax));
        end
      end
      OP_RELEASE: drag = 1'b0;
      OP_MOVE: begin
        if (drag && seen) begin
          g  = longint'(gain);
          az = az - 24'(g * (longint'(pointer_x_i) - longint'(lx)));
          e  = longint'($signed(el)) + g * (longint'(pointer_y_i) - longint'(ly));
          if (e > longint'(elim)) e = longint'(elim);
          if (e < -longint'(elim)) e = -longint'(elim);
          el = 24'(e);
        end
        lx = pointer_x_i;
        ly = pointer_y_i;
        seen = 1'b1;
      end
      default: predict_view();
    endcase
  endtask

  task automatic compare_column();
    column_t c;
    logic [31:0] got [4];
    got = '{row0_i, row1_i, row2_i, row3_i};
    if (columns_q.size() == 0) begin
      errors_o++;
      $error("unexpected result column=%0d", column_i);
      return;
    end
    c = columns_q.pop_front();
    if (column_i !== c.col) begin
      errors_o++;
      $error("column expected %0d actual %0d", c.col, column_i);
    end
    if (last_i !== c.lst) begin
      errors_o++;
      $error("last expected %0d actual %0d", c.lst, last_i);
    end
    for (int j = 0; j < 4; j++)
      if (got[j] !== c.r[j]) begin
        errors_o++;
        $error("row%0d expected %0d actual %0d", j, $signed(c.r[j]), $signed(got[j]));
      end
  endtask

  assign pending_o = columns_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain = 16'd5340; elim = 22'd3774873;
      rmin = 32'd6553600; rmax = 32'd26214400; rstep = 32'd586172;
      az = '0; el = '0; rad = 32'd19660800;
      drag = 1'b0; seen = 1'b0; lx = '0; ly = '0;
      columns_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ANGLE_GAIN:  gain  = cfg_data_i[15:0];
          REG_ELEV_LIMIT:  elim  = cfg_data_i[21:0];
          REG_RADIUS_MIN:  rmin  = cfg_data_i;
          REG_RADIUS_MAX:  rmax  = cfg_data_i;
          REG_RADIUS_STEP: rstep = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) apply_request();
      if (out_valid_i && out_ready_i) compare_column();
    end
  end

  initial errors_o = 0;

endmodule

// ----- bench/orbit_camera_view_matrix_tb.sv -----
// ----------------------------------------------------------------------------
// orbit_camera_view_matrix_tb
// Drives press, release, move and view requests with random gaps and
// stalls through several register settings; the checker judges results.
// ----------------------------------------------------------------------------
module orbit_camera_view_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ocvm_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i = '0;
  logic [1:0]         button_i = '0;
  logic signed [15:0] pointer_x_i = '0;
  logic signed [15:0] pointer_y_i = '0;
  logic               ui_consumed_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         column_o;
  logic               last_o;
  logic signed [31:0] row0_o, row1_o, row2_o, row3_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  int                 errors;
  int                 pending;
  logic               stim_done = 1'b0;
  logic signed [15:0] px = '0, py = '0;

  always #10 clk_i = ~clk_i;

  orbit_camera_view_matrix dut (.*);

  ocvm_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .button_i,
    .pointer_x_i, .pointer_y_i, .ui_consumed_i,
    .out_valid_i(out_valid_o), .out_ready_i, .column_i(column_o), .last_i(last_o),
    .row0_i(row0_o), .row1_i(row1_o), .row2_i(row2_o), .row3_i(row3_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk_i) begin
    if (!stim_done && $urandom_range(0, 99) < 3) out_ready_i <= 1'b1;
    else if (stim_done || $urandom_range(0, 3) != 0) out_ready_i <= (gap_len() == 0)
      || $urandom_range(0, 1);
    else out_ready_i <= 1'b0;
  end

  task automatic send(input op_e op, input logic [1:0] btn, input logic signed [15:0] x,
                      input logic signed [15:0] y, input logic uic);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    button_i      <= btn;
    pointer_x_i   <= x;
    pointer_y_i   <= y;
    ui_consumed_i <= uic;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      send(OP_PRESS, 2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
           $urandom_range(0, 4) == 0);
    end else if (r < 25) begin
      send(OP_RELEASE, 2'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    end else if (r < 70) begin
      if ($urandom_range(0, 9) == 0) begin
        px = 16'($urandom); py = 16'($urandom);
      end else begin
        px = px + 16'($signed(8'($urandom)));
        py = py + 16'($signed(8'($urandom)));
      end
      send(OP_MOVE, 2'($urandom), px, py, 1'($urandom));
    end else begin
      send(OP_VIEW, 2'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(OP_VIEW, 2'd0, 16'sd0, 16'sd0, 1'b0);
    send(OP_PRESS, BTN_SCROLL_UP, 16'sd0, 16'sd0, 1'b1);
    send(OP_PRESS, 2'd3, 16'sd0, 16'sd0, 1'b0);
    send(OP_MOVE, 2'd0, 16'sd100, -16'sd50, 1'b0);
    send(OP_MOVE, 2'd0, 16'sh7FFF, -16'sh8000, 1'b0);
    send(OP_VIEW, 2'd0, 16'sd0, 16'sd0, 1'b0);
    send(OP_MOVE, 2'd0, -16'sh8000, 16'sh7FFF, 1'b0);
    send(OP_VIEW, 2'd0, 16'sd0, 16'sd0, 1'b0);
    send(OP_PRESS, BTN_SCROLL_DOWN, 16'sd0, 16'sd0, 1'b0);
    send(OP_PRESS, BTN_SCROLL_UP, 16'sd0, 16'sd0, 1'b0);
    send(OP_RELEASE, 2'd0, 16'sd0, 16'sd0, 1'b1);
    send(OP_MOVE, 2'd0, 16'sd3, 16'sd3, 1'b0);
    send(OP_VIEW, 2'd0, 16'sd0, 16'sd0, 1'b0);
    drain();
    // zero radius, large radius, extreme gains and bounds
    write_reg(REG_RADIUS_MIN, 32'd0);
    write_reg(REG_RADIUS_STEP, 32'hFFFF_FFFF);
    write_reg(REG_RADIUS_MAX, 32'hFFFF_FFFF);
    write_reg(REG_ANGLE_GAIN, 32'hFFFF);
    write_reg(REG_ELEV_LIMIT, 32'h3F_FFFF);
    send(OP_PRESS, BTN_SCROLL_DOWN, 16'sd0, 16'sd0, 1'b0);
    send(OP_VIEW, 2'd0, 16'sd0, 16'sd0, 1'b0);
    send(OP_PRESS, BTN_SCROLL_UP, 16'sd0, 16'sd0, 1'b0);
    send(OP_VIEW, 2'd0, 16'sd0, 16'sd0, 1'b0);
    drain();
    write_reg(REG_RADIUS_STEP, 32'd0);
    write_reg(REG_RADIUS_MAX, 32'd0);
    send(OP_PRESS, BTN_SCROLL_DOWN, 16'sd0, 16'sd0, 1'b0);
    send(OP_VIEW, 2'd0, 16'sd0, 16'sd0, 1'b0);
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_ANGLE_GAIN, 32'd5340);
          write_reg(REG_ELEV_LIMIT, 32'd3774873);
          write_reg(REG_RADIUS_MIN, 32'd6553600);
          write_reg(REG_RADIUS_MAX, 32'd26214400);
          write_reg(REG_RADIUS_STEP, 32'd586172);
        end
        1: begin
          write_reg(REG_ANGLE_GAIN, 32'd0);
          write_reg(REG_ELEV_LIMIT, 32'd0);
          write_reg(REG_RADIUS_STEP, 32'h8000_0000);
          write_reg(REG_RADIUS_MAX, 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(REG_ANGLE_GAIN, $urandom_range(0, 65535));
          write_reg(REG_ELEV_LIMIT, $urandom_range(0, 4194303));
          write_reg(REG_RADIUS_MIN, $urandom);
          write_reg(REG_RADIUS_MAX, $urandom);
          write_reg(REG_RADIUS_STEP, $urandom_range(0, 32'h0400_0000));
        end
      endcase
      repeat (75) random_request();
      drain();
    end
    stim_done <= 1'b1;
    drain();
    if (errors == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
